[hw/rtl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg - shared types and helpers for the fixed-point ALU
// Opcodes, error codes, the control word that travels down the pipe and the
// limit and saturation helpers used at both ends of the divider.
// ----------------------------------------------------------------------------
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_MUL     = 4'd0,
		OP_DIV     = 4'd1,
		OP_DIV_INT = 4'd2,
		OP_MOD     = 4'd3,
		OP_REM     = 4'd4,
		OP_FLOOR   = 4'd5,
		OP_CEIL    = 4'd6,
		OP_TRUNC   = 4'd7,
		OP_ROUND   = 4'd8,
		OP_ABS     = 4'd9,
		OP_SIGNUM  = 4'd10,
		OP_FPART   = 4'd11,
		OP_MAX_INT = 4'd12
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_OVF  = 2'd1,
		ERR_DIV0 = 2'd2
	} err_t;

	// control word carried alongside the divider data
	typedef struct packed {
		op_t         op;
		logic        a_neg;
		logic        b_neg;
		logic        b_zero;
		logic [31:0] b_val;
		logic [31:0] early_res;
		err_t        early_err;
	} ctl_t;

	typedef struct packed {
		logic               ovf;
		logic signed [63:0] val;
	} chk_t;

	function automatic chk_t limit_check(input logic signed [63:0] v, input logic [30:0] lim);
		logic signed [63:0] l;
		chk_t c;
		l = signed'({33'd0, lim});
		c.ovf = 1'b0;
		c.val = v;
		if (v > l) begin
			c.ovf = 1'b1;
			c.val = l;
		end else if (v < -l) begin
			c.ovf = 1'b1;
			c.val = -l;
		end
		return c;
	endfunction

	function automatic chk_t sat_word(input logic signed [63:0] v, input logic signed [63:0] wmax);
		chk_t c;
		c.ovf = 1'b0;
		c.val = v;
		if (v > wmax) begin
			c.ovf = 1'b1;
			c.val = wmax;
		end else if (v < -wmax - 64'sd1) begin
			c.ovf = 1'b1;
			c.val = -wmax - 64'sd1;
		end
		return c;
	endfunction

endpackage

[hw/rtl/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu - pipelined signed fixed-point arithmetic unit
// Multiply, divide, modulo, rounding and sign operations on raw words,
// one word per cycle through a fully pipelined restoring divider.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (lowest bit first)
// s_*       in   tdata: operand_a[31:0], operand_b[63:32]; tuser: opcode[3:0]
// m_*       out  tdata: result[31:0]; tuser: error_code[1:0]
// cfg_*     in   data: magnitude_limit[30:0]
//
// The pipe has two front stages, one divider step per quotient bit
// (32 + FRAC_BITS steps) and two back stages.
// One word enters every cycle; the whole pipe advances together whenever the
// output register is empty or being taken, so a stall holds every stage.
// Reset clears the valid bits and sets the limit to its maximum.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
	parameter int FRAC_BITS  = 12,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
	input  logic [3:0]  s_tuser,   // opcode[3:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result[31:0]
	output logic [1:0]  m_tuser,   // error_code[1:0]
	// limit register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data   // magnitude_limit[30:0]
);
	import fpa_pkg::*;

	localparam int NB = 32 + FRAC_BITS;

	logic        en;
	logic [30:0] limit_q;

	// divider chain taps: index 0 is the front end's output
	logic          v_d   [0:NB];
	ctl_t          ctl_d [0:NB];
	logic [31:0]   rem_d [0:NB];
	logic [NB-1:0] dq_d  [0:NB];
	logic [31:0]   dvs_d [0:NB];

	// pipe advances when the output word is absent or accepted
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 31'h7FFF_FFFF;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	fpa_front #(
		.FRAC_BITS  (FRAC_BITS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.opcode    (s_tuser),
		.operand_a (s_tdata[31:0]),
		.operand_b (s_tdata[63:32]),
		.limit     (limit_q),
		.valid_s2  (v_d[0]),
		.ctl_s2    (ctl_d[0]),
		.dq_s2     (dq_d[0]),
		.dvs_s2    (dvs_d[0])
	);

	// partial remainder starts empty
	assign rem_d[0] = '0;

	for (genvar k = 0; k < NB; k++) begin : g_div
		fpa_div_step #(
			.NB (NB)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_d[k]),
			.in_ctl   (ctl_d[k]),
			.in_rem   (rem_d[k]),
			.in_dq    (dq_d[k]),
			.in_dvs   (dvs_d[k]),
			.valid_s1 (v_d[k+1]),
			.ctl_s1   (ctl_d[k+1]),
			.rem_s1   (rem_d[k+1]),
			.dq_s1    (dq_d[k+1]),
			.dvs_s1   (dvs_d[k+1])
		);
	end

	fpa_back #(
		.FRAC_BITS  (FRAC_BITS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_d[NB]),
		.in_ctl    (ctl_d[NB]),
		.in_rem    (rem_d[NB]),
		.in_q      (dq_d[NB]),
		.limit     (limit_q),
		.out_valid (m_tvalid),
		.out_res   (m_tdata),
		.out_err   (m_tuser)
	);

endmodule

[hw/rtl/fpa_front.sv]
// ----------------------------------------------------------------------------
// fpa_front - operand preparation and operations that need no divider
// Stage 1 takes magnitudes, builds the dividend and registers the product.
// Stage 2 finishes every operation that does not need the divider.
// ----------------------------------------------------------------------------
module fpa_front #(
	parameter int FRAC_BITS  = 12,
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [3:0]           opcode,
	input  logic [31:0]          operand_a,
	input  logic [31:0]          operand_b,
	input  logic [30:0]          limit,
	output logic                 valid_s2,
	output fpa_pkg::ctl_t        ctl_s2,
	output logic [32+FRAC_BITS-1:0] dq_s2,
	output logic [31:0]          dvs_s2
);
	import fpa_pkg::*;

	localparam int NB = 32 + FRAC_BITS;
	localparam int WB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam logic signed [63:0] WMAX = (64'sd1 <<< (WB - 1)) - 64'sd1;
	localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	logic               valid_s1;
	op_t                op_s1;
	logic [31:0]        a_s1, b_s1;
	logic signed [63:0] prod_s1;
	logic [NB-1:0]      dividend_s1;
	logic [31:0]        divisor_s1;

	logic [31:0]        a_mag, b_mag;
	logic               is_div;

	logic signed [63:0] a64, b64, fl, ce, tr, v;
	chk_t               lc, sc;
	logic               lovf;

	assign a_mag  = operand_a[31] ? (32'd0 - operand_a) : operand_a;
	assign b_mag  = operand_b[31] ? (32'd0 - operand_b) : operand_b;
	assign is_div = (op_t'(opcode) == OP_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1      <= op_t'(opcode);
			a_s1       <= operand_a;
			b_s1       <= operand_b;
			prod_s1    <= signed'(operand_a) * signed'(operand_b);
			dividend_s1 <= is_div ? {a_mag, {FRAC_BITS{1'b0}}}
			                      : {{FRAC_BITS{1'b0}}, a_mag};
			divisor_s1 <= b_mag;
		end
	end

	// operations that do not need the divider
	always_comb begin
		a64  = 64'(signed'(a_s1));
		b64  = 64'(signed'(b_s1));
		fl   = a64 >>> FRAC_BITS;
		ce   = fl + 64'(|a_s1[FRAC_BITS-1:0]);
		tr   = a_s1[31] ? ce : fl;
		v    = '0;
		lovf = 1'b0;
		lc   = limit_check(prod_s1 >>> FRAC_BITS, limit);
		case (op_s1)
			OP_MUL: begin
				v    = lc.val;
				lovf = lc.ovf;
			end
			OP_FLOOR:   v = fl;
			OP_CEIL:    v = ce;
			OP_TRUNC:   v = tr;
			OP_ROUND:   v = (a64 + HALF) >>> FRAC_BITS;
			OP_ABS:     v = a_s1[31] ? -a64 : a64;
			OP_SIGNUM:  v = a_s1[31] ? -ONE : ((a_s1 != 32'd0) ? ONE : 64'sd0);
			OP_FPART:   v = a64 - (tr <<< FRAC_BITS);
			OP_MAX_INT: v = (a64 < (b64 <<< FRAC_BITS)) ? (b64 <<< FRAC_BITS) : a64;
			default:    v = '0;
		endcase
		sc = sat_word(v, WMAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2.op        <= op_s1;
			ctl_s2.a_neg     <= a_s1[31];
			ctl_s2.b_neg     <= b_s1[31];
			ctl_s2.b_zero    <= (b_s1 == 32'd0);
			ctl_s2.b_val     <= b_s1;
			ctl_s2.early_res <= sc.val[31:0];
			ctl_s2.early_err <= (lovf || sc.ovf) ? ERR_OVF : ERR_NONE;
			dq_s2            <= dividend_s1;
			dvs_s2           <= divisor_s1;
		end
	end

endmodule

[hw/rtl/fpa_div_step.sv]
// ----------------------------------------------------------------------------
// fpa_div_step - one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in behind the dividend.
// ----------------------------------------------------------------------------
module fpa_div_step #(
	parameter int NB = 44
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  fpa_pkg::ctl_t in_ctl,
	input  logic [31:0]   in_rem,
	input  logic [NB-1:0] in_dq,
	input  logic [31:0]   in_dvs,
	output logic          valid_s1,
	output fpa_pkg::ctl_t ctl_s1,
	output logic [31:0]   rem_s1,
	output logic [NB-1:0] dq_s1,
	output logic [31:0]   dvs_s1
);
	import fpa_pkg::*;

	logic [31:0] t;
	logic        ge;

	assign t  = {in_rem[30:0], in_dq[NB-1]};
	assign ge = (t >= in_dvs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= in_ctl;
			rem_s1 <= ge ? (t - in_dvs) : t;
			dq_s1  <= {in_dq[NB-2:0], ge};
			dvs_s1 <= in_dvs;
		end
	end

endmodule

[hw/rtl/fpa_back.sv]
// ----------------------------------------------------------------------------
// fpa_back - sign restore, limit check and result selection
// Stage p signs quotient and remainder; for divider ops the output stage
// saturates the word and limits OP_DIV; other ops take the early result.
// ----------------------------------------------------------------------------
module fpa_back #(
	parameter int FRAC_BITS  = 12,
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  fpa_pkg::ctl_t           in_ctl,
	input  logic [31:0]             in_rem,
	input  logic [32+FRAC_BITS-1:0] in_q,
	input  logic [30:0]             limit,
	output logic                    out_valid,
	output logic [31:0]             out_res,
	output logic [1:0]              out_err
);
	import fpa_pkg::*;

	localparam int NB = 32 + FRAC_BITS;
	localparam int WB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam logic signed [63:0] WMAX = (64'sd1 <<< (WB - 1)) - 64'sd1;

	logic               valid_sp;
	ctl_t               ctl_sp;
	logic signed [63:0] val_sp;

	logic signed [63:0] qs, rs, vp;
	chk_t               lc, sc;
	logic signed [63:0] res_c;
	err_t               err_c;

	always_comb begin
		qs = signed'({{(64-NB){1'b0}}, in_q});
		qs = (in_ctl.a_neg ^ in_ctl.b_neg) ? -qs : qs;
		rs = signed'({32'd0, in_rem});
		rs = in_ctl.a_neg ? -rs : rs;
		case (in_ctl.op)
			OP_MOD: vp = ((rs != 64'sd0) && (in_ctl.a_neg != in_ctl.b_neg))
			             ? rs + 64'(signed'(in_ctl.b_val)) : rs;
			OP_REM: vp = rs;
			default: vp = qs;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sp <= 1'b0;
		end else if (en) begin
			valid_sp <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sp <= in_ctl;
			val_sp <= vp;
		end
	end

	always_comb begin
		lc = limit_check(val_sp, limit);
		sc = sat_word((ctl_sp.op == OP_DIV) ? lc.val : val_sp, WMAX);
		res_c = '0;
		err_c = ERR_NONE;
		case (ctl_sp.op)
			OP_DIV, OP_DIV_INT, OP_MOD, OP_REM: begin
				if (ctl_sp.b_zero) begin
					res_c = '0;
					err_c = ERR_DIV0;
				end else begin
					res_c = sc.val;
					err_c = (sc.ovf || ((ctl_sp.op == OP_DIV) && lc.ovf)) ? ERR_OVF : ERR_NONE;
				end
			end
			default: begin
				res_c = 64'(signed'(ctl_sp.early_res));
				err_c = ctl_sp.early_err;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_sp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res <= res_c[31:0];
			out_err <= err_c;
		end
	end

endmodule
